/* src/bidi_pkg.sv */
// bidi_pkg: shared types, constants and decode helpers for the bidi run reorder core
// no dependencies; imported by the core and its checker
`default_nettype none
package bidi_pkg;

    localparam int DEF_MAX_BYTES = 256;
    localparam int DEF_MAX_RUNS  = 256;

    // configuration register indexes
    localparam logic CFG_BASE_MODE = 1'b0;
    localparam logic CFG_OUT_LIMIT = 1'b1;

    // base_mode codes
    localparam logic [1:0] MODE_LTR  = 2'd0;
    localparam logic [1:0] MODE_RTL  = 2'd1;
    localparam logic [1:0] MODE_AUTO = 2'd2;

    localparam logic       REQ_LOAD = 1'b0;
    localparam logic       REQ_READ = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] text_byte;
        logic       last_byte;
    } bidi_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_end;
        logic [8:0] total_bytes;
        logic       dir_used;
        logic       input_overflow;
    } bidi_res_t;

    typedef struct packed {
        logic [2:0]  len;
        logic [20:0] cp;
    } bidi_dec_t;

    // lenient utf-8 decode; missing bytes read as zero
    function automatic bidi_dec_t lenient_decode(input logic [7:0] b0, input logic [7:0] b1,
                                                 input logic [7:0] b2, input logic [7:0] b3);
        bidi_dec_t d;
        d.len = 3'd1;
        d.cp  = {13'd0, b0};
        if (b0 < 8'h80) begin
            d.len = 3'd1;
        end else if ((b0 & 8'hE0) == 8'hC0 && b1 != 8'd0) begin
            d.len = 3'd2;
            d.cp  = {10'd0, b0[4:0], b1[5:0]};
        end else if ((b0 & 8'hF0) == 8'hE0 && b1 != 8'd0 && b2 != 8'd0) begin
            d.len = 3'd3;
            d.cp  = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
        end else if ((b0 & 8'hF8) == 8'hF0 && b1 != 8'd0 && b2 != 8'd0 && b3 != 8'd0) begin
            d.len = 3'd4;
            d.cp  = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        end
        return d;
    endfunction

    function automatic logic is_rtl(input logic [20:0] cp);
        return (cp >= 21'h0590 && cp <= 21'h07FF) || (cp >= 21'hFB1D && cp <= 21'hFEFF);
    endfunction

    function automatic logic is_ltr(input logic [20:0] cp);
        return (cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A)
            || (cp >= 21'h00C0 && cp <= 21'h024F) || (cp >= 21'h0370 && cp <= 21'h04FF);
    endfunction

endpackage
`default_nettype wire

/* src/bidi_ram.sv */
// bidi_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`default_nettype none
module bidi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* src/bidi_run_reorder_core.sv */
// bidi_run_reorder_core: top level, loads utf-8 text, reorders directional runs, serves bytes
// depends on bidi_pkg and bidi_ram
//
// usage: every input item is a load (req_type 0) or a read (req_type 1). a load stores one
// nonzero text byte; a load flagged last_byte starts the analysis, during which in_stall
// stays high. analysis is a sequencer over the text memory: a direction scan over the
// decoded characters (base_mode auto only), a run split, then, run by run, a backward
// lead-byte scan per character of rtl runs and a byte copy into the output memory.
// a read returns one result item, registered from the output memory data in S_RD_WAIT;
// one read is in flight at a time and the next read waits until that result is taken.
// results sit in an output register until res_stall drops; a read is stalled while a
// result still waits, loads are taken meanwhile. configuration is written through
// cfg_valid/cfg_ready (always ready); base_mode takes effect at the next analysis, while
// out_limit is read during the output phase of an analysis.
// reset (rst_n low, asynchronous) returns to the loading phase with an empty string,
// base_mode auto and out_limit 257; the memories are not cleared.
`default_nettype none
module bidi_run_reorder_core
    import bidi_pkg::*;
#(
    parameter int MAX_BYTES = DEF_MAX_BYTES,
    parameter int MAX_RUNS  = DEF_MAX_RUNS
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire bidi_in_t  in_item,
    output logic           res_valid,
    input  wire logic      res_stall,
    output bidi_res_t      res_item,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic      cfg_index,
    input  wire logic [8:0] cfg_data
);
    localparam int AW   = $clog2(MAX_BYTES);
    localparam int OW   = $clog2(MAX_BYTES + 1);
    localparam int RAW  = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int RW   = $clog2(MAX_RUNS + 1);
    localparam int RUNW = AW + OW + 1;
    localparam int CMPW = ((OW > 9) ? OW : 9) + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_RD_WAIT, S_START, S_DEC_RD, S_DEC_CAP,
        S_DIR_CHK, S_DIR_EVAL, S_RUN_CHK, S_RUN_FIRST, S_RUN_CONT, S_RUN_EVAL, S_RUN_WR,
        S_EMIT_NEXT, S_RUN_LD, S_RUN_END, S_RTL_CHK, S_BK_RD, S_BK_CAP, S_CHAR,
        S_COPY_RD, S_COPY_WR, S_FINISH
    } state_t;

    state_t          state_reg, ret_reg;
    logic [1:0]      base_mode_reg;
    logic [8:0]      out_limit_reg;
    logic [OW-1:0]   count_reg, i_reg, start_reg, len_reg, pos_reg, ce_reg, src_reg, cnt_reg;
    logic [OW-1:0]   oi_reg, total_reg, emitted_reg;
    logic [RW-1:0]   rc_reg, k_reg;
    logic [1:0]      dcnt_reg;
    logic [7:0]      win_reg [4];
    logic            phase_reg, overflow_reg, dir_reg, run_rtl_reg;
    logic            res_valid_reg;
    bidi_res_t       res_item_reg, res_item_next;

    logic            text_we, out_we, run_we;
    logic [AW-1:0]   text_waddr, text_raddr, out_raddr;
    logic [7:0]      text_wdata, text_rdata, out_rdata;
    logic [RAW-1:0]  run_raddr;
    logic [RUNW-1:0] run_rdata, run_wdata;

    bidi_dec_t       dec;
    logic            cp_rtl, cp_ltr;
    logic [OW:0]     dec_addr;
    logic [OW-1:0]   count_eff;
    logic            in_fire;
    logic [CMPW-1:0] cap_x, oi_x;
    logic [AW-1:0]   r_start;
    logic [OW-1:0]   r_len;
    logic            r_rtl;
    logic [RW-1:0]   r_idx;

    assign in_fire   = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE) || (res_valid_reg && in_item.req_type == REQ_READ);
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    assign dec      = lenient_decode(win_reg[0], win_reg[1], win_reg[2], win_reg[3]);
    assign cp_rtl   = is_rtl(dec.cp);
    assign cp_ltr   = is_ltr(dec.cp);
    assign dec_addr = {1'b0, i_reg} + (OW+1)'(dcnt_reg);
    assign count_eff = phase_reg ? '0 : count_reg;
    assign cap_x    = (out_limit_reg == 9'd0) ? '0 : CMPW'(out_limit_reg - 9'd1);
    assign oi_x     = CMPW'(oi_reg);
    assign {r_start, r_len, r_rtl} = run_rdata;
    assign r_idx    = dir_reg ? (rc_reg - RW'(1) - k_reg) : k_reg;

    assign text_we    = in_fire && in_item.req_type == REQ_LOAD && in_item.text_byte != 8'd0
                        && count_eff < OW'(MAX_BYTES);
    assign text_waddr = count_eff[AW-1:0];
    assign text_wdata = in_item.text_byte;
    assign out_raddr  = emitted_reg[AW-1:0];
    assign run_we     = (state_reg == S_RUN_WR);
    assign run_wdata  = {start_reg[AW-1:0], OW'(i_reg - start_reg), run_rtl_reg};
    assign run_raddr  = r_idx[RAW-1:0];
    assign out_we     = (state_reg == S_COPY_WR);

    always_comb
    begin
        case (state_reg)
            S_BK_RD:   text_raddr = pos_reg[AW-1:0];
            S_COPY_RD: text_raddr = src_reg[AW-1:0];
            default:   text_raddr = dec_addr[AW-1:0];
        endcase
    end

    // result of the read in flight, built from the output memory data
    always_comb
    begin
        res_item_next = '0;
        res_item_next.input_overflow = overflow_reg;
        if (phase_reg)
        begin
            res_item_next.total_bytes = 9'(total_reg);
            res_item_next.dir_used    = dir_reg;
            if (emitted_reg < total_reg)
            begin
                res_item_next.out_byte  = out_rdata;
                res_item_next.out_valid = 1'b1;
                res_item_next.out_end   = (emitted_reg + OW'(1) == total_reg);
            end
            else
            begin
                res_item_next.out_end = 1'b1;
            end
        end
    end

    bidi_ram #(.WIDTH(8), .DEPTH(MAX_BYTES)) u_text_ram (
        .clk(clk), .we(text_we), .waddr(text_waddr), .wdata(text_wdata),
        .raddr(text_raddr), .rdata(text_rdata)
    );

    bidi_ram #(.WIDTH(8), .DEPTH(MAX_BYTES)) u_out_ram (
        .clk(clk), .we(out_we), .waddr(oi_reg[AW-1:0]), .wdata(text_rdata),
        .raddr(out_raddr), .rdata(out_rdata)
    );

    bidi_ram #(.WIDTH(RUNW), .DEPTH(MAX_RUNS)) u_run_ram (
        .clk(clk), .we(run_we), .waddr(rc_reg[RAW-1:0]), .wdata(run_wdata),
        .raddr(run_raddr), .rdata(run_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            base_mode_reg <= MODE_AUTO;
            out_limit_reg <= 9'd257;
            count_reg     <= '0;
            total_reg     <= '0;
            emitted_reg   <= '0;
            rc_reg        <= '0;
            phase_reg     <= 1'b0;
            overflow_reg  <= 1'b0;
            dir_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            res_item_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_BASE_MODE)
                begin
                    base_mode_reg <= cfg_data[1:0];
                end
                else
                begin
                    out_limit_reg <= cfg_data;
                end
            end
            if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && in_item.req_type == REQ_LOAD)
                    begin
                        if (phase_reg)
                        begin
                            phase_reg    <= 1'b0;
                            emitted_reg  <= '0;
                            total_reg    <= '0;
                            dir_reg      <= 1'b0;
                        end
                        if (in_item.text_byte != 8'd0)
                        begin
                            if (count_eff < OW'(MAX_BYTES))
                            begin
                                count_reg    <= count_eff + OW'(1);
                                overflow_reg <= phase_reg ? 1'b0 : overflow_reg;
                            end
                            else
                            begin
                                count_reg    <= count_eff;
                                overflow_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            count_reg <= count_eff;
                            if (phase_reg)
                            begin
                                overflow_reg <= 1'b0;
                            end
                        end
                        if (in_item.last_byte)
                        begin
                            state_reg <= S_START;
                        end
                    end
                    else if (in_fire)
                    begin
                        state_reg <= S_RD_WAIT;
                    end
                end
                S_RD_WAIT:
                begin
                    res_valid_reg <= 1'b1;
                    res_item_reg  <= res_item_next;
                    if (phase_reg && emitted_reg < total_reg)
                    begin
                        emitted_reg <= emitted_reg + OW'(1);
                    end
                    state_reg <= S_IDLE;
                end
                S_START:
                begin
                    i_reg  <= '0;
                    rc_reg <= '0;
                    if (base_mode_reg == MODE_AUTO)
                    begin
                        state_reg <= S_DIR_CHK;
                    end
                    else
                    begin
                        dir_reg   <= (base_mode_reg == MODE_RTL);
                        state_reg <= S_RUN_CHK;
                    end
                end
                S_DEC_RD:
                begin
                    state_reg <= S_DEC_CAP;
                end
                S_DEC_CAP:
                begin
                    win_reg[dcnt_reg] <= (dec_addr < (OW+1)'(count_reg)) ? text_rdata : 8'd0;
                    dcnt_reg <= dcnt_reg + 2'd1;
                    state_reg <= (dcnt_reg == 2'd3) ? ret_reg : S_DEC_RD;
                end
                S_DIR_CHK:
                begin
                    if (i_reg < count_reg)
                    begin
                        dcnt_reg  <= '0;
                        ret_reg   <= S_DIR_EVAL;
                        state_reg <= S_DEC_RD;
                    end
                    else
                    begin
                        dir_reg   <= 1'b0;
                        i_reg     <= '0;
                        state_reg <= S_RUN_CHK;
                    end
                end
                S_DIR_EVAL:
                begin
                    if (cp_rtl || cp_ltr)
                    begin
                        dir_reg   <= cp_rtl;
                        i_reg     <= '0;
                        state_reg <= S_RUN_CHK;
                    end
                    else
                    begin
                        i_reg     <= i_reg + OW'(dec.len);
                        state_reg <= S_DIR_CHK;
                    end
                end
                S_RUN_CHK:
                begin
                    if (i_reg < count_reg && rc_reg < RW'(MAX_RUNS))
                    begin
                        start_reg <= i_reg;
                        dcnt_reg  <= '0;
                        ret_reg   <= S_RUN_FIRST;
                        state_reg <= S_DEC_RD;
                    end
                    else
                    begin
                        k_reg     <= '0;
                        oi_reg    <= '0;
                        state_reg <= S_EMIT_NEXT;
                    end
                end
                S_RUN_FIRST:
                begin
                    run_rtl_reg <= cp_rtl;
                    i_reg       <= i_reg + OW'(dec.len);
                    state_reg   <= S_RUN_CONT;
                end
                S_RUN_CONT:
                begin
                    if (i_reg < count_reg)
                    begin
                        dcnt_reg  <= '0;
                        ret_reg   <= S_RUN_EVAL;
                        state_reg <= S_DEC_RD;
                    end
                    else
                    begin
                        state_reg <= S_RUN_WR;
                    end
                end
                S_RUN_EVAL:
                begin
                    if (run_rtl_reg ? cp_ltr : cp_rtl)
                    begin
                        state_reg <= S_RUN_WR;
                    end
                    else
                    begin
                        i_reg     <= i_reg + OW'(dec.len);
                        state_reg <= S_RUN_CONT;
                    end
                end
                S_RUN_WR:
                begin
                    rc_reg    <= rc_reg + RW'(1);
                    state_reg <= S_RUN_CHK;
                end
                S_EMIT_NEXT:
                begin
                    state_reg <= (k_reg == rc_reg) ? S_FINISH : S_RUN_LD;
                end
                S_RUN_LD:
                begin
                    start_reg <= OW'(r_start);
                    if (oi_x >= cap_x)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else if (r_rtl)
                    begin
                        pos_reg   <= OW'(r_start) + r_len;
                        state_reg <= S_RTL_CHK;
                    end
                    else
                    begin
                        src_reg <= OW'(r_start);
                        // ltr copy is cut at capacity
                        if (oi_x + CMPW'(r_len) > cap_x)
                        begin
                            cnt_reg <= OW'(cap_x - oi_x);
                        end
                        else
                        begin
                            cnt_reg <= r_len;
                        end
                        ret_reg   <= S_RUN_END;
                        state_reg <= S_COPY_RD;
                    end
                end
                S_RUN_END:
                begin
                    k_reg     <= k_reg + RW'(1);
                    state_reg <= S_EMIT_NEXT;
                end
                S_RTL_CHK:
                begin
                    if (pos_reg > start_reg && oi_x < cap_x)
                    begin
                        ce_reg    <= pos_reg;
                        pos_reg   <= pos_reg - OW'(1);
                        state_reg <= S_BK_RD;
                    end
                    else
                    begin
                        state_reg <= S_RUN_END;
                    end
                end
                S_BK_RD:
                begin
                    state_reg <= (pos_reg > start_reg) ? S_BK_CAP : S_CHAR;
                end
                S_BK_CAP:
                begin
                    // step back over continuation bytes to the lead byte
                    if ((text_rdata & 8'hC0) == 8'h80)
                    begin
                        pos_reg   <= pos_reg - OW'(1);
                        state_reg <= S_BK_RD;
                    end
                    else
                    begin
                        state_reg <= S_CHAR;
                    end
                end
                S_CHAR:
                begin
                    // a character that does not fit is skipped
                    if (oi_x + CMPW'(ce_reg - pos_reg) <= cap_x)
                    begin
                        src_reg   <= pos_reg;
                        cnt_reg   <= ce_reg - pos_reg;
                        ret_reg   <= S_RTL_CHK;
                        state_reg <= S_COPY_RD;
                    end
                    else
                    begin
                        state_reg <= S_RTL_CHK;
                    end
                end
                S_COPY_RD:
                begin
                    state_reg <= (cnt_reg == '0) ? ret_reg : S_COPY_WR;
                end
                S_COPY_WR:
                begin
                    oi_reg    <= oi_reg + OW'(1);
                    src_reg   <= src_reg + OW'(1);
                    cnt_reg   <= cnt_reg - OW'(1);
                    state_reg <= S_COPY_RD;
                end
                S_FINISH:
                begin
                    total_reg   <= oi_reg;
                    emitted_reg <= '0;
                    phase_reg   <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

/* src/bidi_checker.sv */
// bidi_checker: port-level assertions for bidi_run_reorder_core, bound to the top level
// depends on bidi_pkg
`default_nettype none
module bidi_checker
    import bidi_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      res_valid,
    input wire logic      res_stall,
    input wire bidi_res_t res_item
);
    // a held result keeps its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("result changed while stalled");

    // text bytes are never zero, so a carried byte is nonzero
    a_byte_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.out_valid |-> res_item.out_byte != 8'd0)
        else $error("carried byte is zero");

    // no byte means a zero byte field
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.out_valid |-> res_item.out_byte == 8'd0)
        else $error("empty item with nonzero byte");
endmodule

bind bidi_run_reorder_core bidi_checker u_bidi_checker (
    .clk(clk), .rst_n(rst_n), .res_valid(res_valid), .res_stall(res_stall),
    .res_item(res_item)
);
`default_nettype wire
